### design/rssc_pkg.sv
// rssc_pkg: shared types and constants for the range sum run counter
// no dependencies

package rssc_pkg;

    localparam int SUM_W   = 48;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        t_BK_IDLE,
        t_BK_SCAN,
        t_BK_EMIT
    } t_bk_state;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic              store;
        logic              last;
        logic              ovf;
        logic [SUM_W-1:0]  sum;
    } t_job;

endpackage

### design/rssc_front.sv
// rssc_front: accepts items, keeps the running sum and item count, classifies
// each item as stored or dropped; depends on rssc_pkg

module rssc_front #(
    parameter int MAX_ITEMS = 1024,
    parameter int CNT_W     = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [rssc_pkg::VALUE_W-1:0] i_value,
    input  logic                          i_is_last,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output rssc_pkg::t_job                o_job
);
    import rssc_pkg::*;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             w_acc, w_room;
    logic [SUM_W-1:0] w_new;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign w_acc       = i_valid && i_job_ready;
    assign w_room      = r_cnt < CNT_W'(MAX_ITEMS);
    assign w_new       = r_sum + {{(SUM_W-VALUE_W){i_value[VALUE_W-1]}}, i_value};

    always_comb begin
        o_job.store = w_room;
        o_job.last  = i_is_last;
        o_job.ovf   = r_ovf || !w_room;
        o_job.sum   = w_new;
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (w_acc) begin
            if (w_room) begin
                n_sum = w_new;
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_is_last) begin
                n_sum = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

### design/rssc_queue.sv
// rssc_queue: two-entry queue between front and back
// depends on rssc_pkg

module rssc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rssc_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output rssc_pkg::t_job o_job
);
    import rssc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_n;
    logic       w_push, w_pop;

    assign o_ready = r_n != 2'd2;
    assign o_valid = r_n != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_n <= r_n + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

### design/rssc_back.sv
// rssc_back: prefix memory, pairwise range scan and result register
// depends on rssc_pkg

module rssc_back #(
    parameter int MAX_ITEMS = 1024,
    parameter int CNT_W     = 11,
    parameter int ADDR_W    = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [rssc_pkg::SUM_W-1:0] i_lower,
    input  logic signed [rssc_pkg::SUM_W-1:0] i_upper,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rssc_pkg::t_job                i_job,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rssc_pkg::COUNT_W-1:0]  o_run_count,
    output logic                          o_overflow
);
    import rssc_pkg::*;

    logic [SUM_W-1:0]   r_mem [MAX_ITEMS];
    logic [SUM_W-1:0]   r_rd;
    t_bk_state          r_st, n_st;
    t_job               r_job;
    logic [CNT_W-1:0]   r_n, r_j;
    logic               r_rdv;
    logic [COUNT_W-1:0] r_acc;
    logic               r_ov_valid;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_ovf;
    logic               w_take, w_hit0, w_hitj, w_scan_done, w_out_free;
    logic signed [SUM_W-1:0] w_diff;

    function automatic logic in_rng(input logic signed [SUM_W-1:0] d,
                                    input logic signed [SUM_W-1:0] lo,
                                    input logic signed [SUM_W-1:0] hi);
        in_rng = (d >= lo) && (d <= hi);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic b);
        sat_add = (b && a != COUNT_MAX) ? a + COUNT_W'(1) : a;
    endfunction

    assign o_ready     = r_st == t_BK_IDLE;
    assign w_take      = i_valid && o_ready;
    assign w_out_free  = !r_ov_valid || i_ready;
    assign w_diff      = $signed(r_job.sum) - $signed(r_rd);
    assign w_hit0      = in_rng($signed(i_job.sum), i_lower, i_upper);
    assign w_hitj      = r_rdv && in_rng(w_diff, i_lower, i_upper);
    assign w_scan_done = (r_j >= r_n) && !r_rdv;
    assign o_valid     = r_ov_valid;
    assign o_run_count = r_out_cnt;
    assign o_overflow  = r_out_ovf;

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_BK_IDLE: begin
                if (w_take) begin
                    if (i_job.store) begin
                        n_st = t_BK_SCAN;
                    end else if (i_job.last) begin
                        n_st = t_BK_EMIT;
                    end
                end
            end
            t_BK_SCAN: begin
                if (w_scan_done) begin
                    n_st = r_job.last ? t_BK_EMIT : t_BK_IDLE;
                end
            end
            t_BK_EMIT: begin
                if (w_out_free) begin
                    n_st = t_BK_IDLE;
                end
            end
            default: n_st = t_BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == t_BK_SCAN && r_j < r_n) begin
            r_rd <= r_mem[r_j[ADDR_W-1:0]];
        end
        if (r_st == t_BK_SCAN && w_scan_done) begin
            r_mem[r_n[ADDR_W-1:0]] <= r_job.sum;
        end
        if (w_take) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= t_BK_IDLE;
            r_n        <= '0;
            r_j        <= '0;
            r_rdv      <= 1'b0;
            r_acc      <= '0;
            r_ov_valid <= 1'b0;
            r_out_cnt  <= '0;
            r_out_ovf  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == t_BK_EMIT && w_out_free) begin
                r_ov_valid <= 1'b1;
            end else if (r_ov_valid && i_ready) begin
                r_ov_valid <= 1'b0;
            end
            case (r_st)
                t_BK_IDLE: begin
                    r_j   <= '0;
                    r_rdv <= 1'b0;
                    if (w_take && i_job.store) begin
                        r_acc <= sat_add(r_acc, w_hit0);
                    end
                end
                t_BK_SCAN: begin
                    r_acc <= sat_add(r_acc, w_hitj);
                    r_rdv <= r_j < r_n;
                    if (r_j < r_n) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    if (w_scan_done) begin
                        r_n <= r_n + CNT_W'(1);
                    end
                end
                t_BK_EMIT: begin
                    if (w_out_free) begin
                        r_out_cnt  <= r_acc;
                        r_out_ovf  <= r_job.ovf;
                        r_acc      <= '0;
                        r_n        <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### design/range_sum_subarray_counter.sv
// range_sum_subarray_counter: top level, config registers, front, queue, back
// depends on rssc_pkg, rssc_front, rssc_queue, rssc_back
//
// usage: send values on i_valid/o_ready with i_is_last on the final one;
// one transaction with o_run_count and o_overflow follows each final item.
// bounds are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// the front adds each value to the running sum and hands it through a
// two-entry queue; the back compares the new prefix with every stored
// prefix, one memory read per cycle through the single read port of the
// prefix memory, and takes no new item until that scan is done.
// a dropped item beyond MAX_ITEMS is taken by the back without a scan.
// after the last scan the back enters its emit state, which loads the
// result register when free; the result is held until taken by i_ready;
// while it waits, the next sequence can already be accepted and scanned.
// reset clears counts, bounds and flags; the prefix memory needs no clearing.

module range_sum_subarray_counter #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_value,
    input  logic                i_is_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [19:0]         o_run_count,
    output logic                o_overflow
);
    import rssc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [SUM_W-1:0] r_lower, r_upper;
    logic             w_fv, w_fr, w_bv, w_br;
    t_job             w_fjob, w_bjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LOWER) begin
                r_lower <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_UPPER) begin
                r_upper <= i_cfg_data;
            end
        end
    end

    rssc_front #(.MAX_ITEMS(MAX_ITEMS), .CNT_W(CNT_W)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_value, .i_is_last,
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );

    rssc_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fjob),
        .o_valid(w_bv), .i_ready(w_br), .o_job(w_bjob)
    );

    rssc_back #(.MAX_ITEMS(MAX_ITEMS), .CNT_W(CNT_W), .ADDR_W(ADDR_W)) u_back (
        .i_clk, .i_rst_n, .i_lower(r_lower), .i_upper(r_upper),
        .i_valid(w_bv), .o_ready(w_br), .i_job(w_bjob),
        .o_valid, .i_ready, .o_run_count, .o_overflow
    );

endmodule
